/* src/indexed_pair_list_insert_remove_assert.svh */
// Assertion macros used by the pair list top module.
`ifndef INDEXED_PAIR_LIST_INSERT_REMOVE_ASSERT_SVH
`define INDEXED_PAIR_LIST_INSERT_REMOVE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ipl_pkg.sv */
package ipl_pkg;

  // Fixed widths of the command and result fields.
  localparam int unsigned POS_W   = 4;
  localparam int unsigned CNT_O_W = 5;
  localparam int unsigned FIELD_W = 32;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_READ   = 2'd3
  } ipl_cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } ipl_status_e;

  // Shift control broadcast to every cell of the row.
  typedef struct packed {
    logic ins;  // open a slot at the selected index and load the new pair
    logic rem;  // close the slot at the selected index
  } ipl_shift_t;

endpackage

/* src/ipl_cell.sv */
module ipl_cell import ipl_pkg::*; #(
  parameter int unsigned INDEX   = 0,
  parameter int unsigned IDX_W   = 4,
  parameter int unsigned PAIR_W  = 64
) (
  input  logic              clk_i,
  input  ipl_shift_t        shift_i,
  input  logic [IDX_W-1:0]  sel_i,
  input  logic [PAIR_W-1:0] new_i,
  input  logic [PAIR_W-1:0] lower_i,
  input  logic [PAIR_W-1:0] upper_i,
  output logic [PAIR_W-1:0] data_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [PAIR_W-1:0] data_q;
  logic [PAIR_W-1:0] data_d;

  // Each cell decides from its own index whether it loads, shifts or holds.
  always_comb begin
    priority if (shift_i.ins && (sel_i == MyIdx)) begin
      data_d = new_i;
    end else if (shift_i.ins && (MyIdx > sel_i)) begin
      data_d = lower_i;
    end else if (shift_i.rem && (MyIdx >= sel_i)) begin
      data_d = upper_i;
    end else begin
      data_d = data_q;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* src/ipl_ctrl.sv */
module ipl_ctrl import ipl_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                               req_i,
  input  ipl_cmd_e                           cmd_i,
  input  logic [POS_W-1:0]                   position_i,
  input  logic [$clog2(CAPACITY+1)-1:0]      count_i,
  output ipl_shift_t                         shift_o,
  output logic [$clog2(CAPACITY)-1:0]        sel_o,
  output ipl_status_e                        status_o,
  output logic                               take_pair_o,
  output logic [$clog2(CAPACITY+1)-1:0]      count_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CmpW = ((CntW > POS_W) ? CntW : POS_W) + 1;

  logic [CmpW-1:0] cnt_x;
  logic [CmpW-1:0] pos_x;
  logic            full;

  assign cnt_x = CmpW'(count_i);
  assign pos_x = CmpW'(position_i);
  assign full  = (cnt_x == CmpW'(CAPACITY));

  // Append writes at the current end of the list.
  assign sel_o = (cmd_i == CMD_APPEND) ? cnt_x[IdxW-1:0] : pos_x[IdxW-1:0];

  // Decode the request into a status, a shift, a pair-take flag and the next count.
  always_comb begin
    status_o    = ST_OK;
    shift_o     = '0;
    take_pair_o = 1'b0;
    count_o     = count_i;
    unique case (cmd_i)
      CMD_APPEND: begin
        if (full) begin
          status_o = ST_FULL;
        end else begin
          shift_o.ins = req_i;
          count_o     = count_i + 1'b1;
        end
      end
      CMD_INSERT: begin
        if (full) begin
          status_o = ST_FULL;
        end else if (pos_x > cnt_x) begin
          status_o = ST_RANGE;
        end else begin
          shift_o.ins = req_i;
          count_o     = count_i + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (pos_x >= cnt_x) begin
          status_o = ST_RANGE;
        end else begin
          shift_o.rem = req_i;
          take_pair_o = 1'b1;
          count_o     = count_i - 1'b1;
        end
      end
      CMD_READ: begin
        if (pos_x >= cnt_x) begin
          status_o = ST_RANGE;
        end else begin
          take_pair_o = 1'b1;
        end
      end
      default: begin
        status_o = ST_RANGE;
      end
    endcase
  end

endmodule

/* src/indexed_pair_list_insert_remove.sv */
// Latency: the result of a request is on the result ports in the cycle after start is taken.
// Throughput: one request per clock cycle; busy stays low, since the row of cells moves each
// entry at or above the selected index one place in the cycle the request is taken.
// Reset clears the entry count and the result strobe; the stored pairs keep no reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "indexed_pair_list_insert_remove_assert.svh"

module indexed_pair_list_insert_remove import ipl_pkg::*; #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic [FIELD_W-1:0] first_value_i,
  input  logic [FIELD_W-1:0] second_value_i,
  output logic               result_valid_o,
  output logic [1:0]         status_o,
  output logic [FIELD_W-1:0] pair_first_o,
  output logic [FIELD_W-1:0] pair_second_o,
  output logic [CNT_O_W-1:0] entry_count_o
);

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW  = $clog2(CAPACITY);
  localparam int unsigned PairW = 2 * VALUE_WIDTH;

  logic              req;
  ipl_cmd_e          cmd;
  ipl_shift_t        shift;
  logic [IdxW-1:0]   sel;
  ipl_status_e       status;
  logic              take_pair;
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   count_d;
  logic [CntW-1:0]   count_next;
  logic [PairW-1:0]  new_pair;
  logic [PairW-1:0]  rd_pair;
  logic [PairW-1:0]  cell_q [CAPACITY];

  logic                   valid_q;
  ipl_status_e            status_q;
  logic [VALUE_WIDTH-1:0] first_q;
  logic [VALUE_WIDTH-1:0] second_q;

  assign busy = 1'b0;
  assign req  = start && !busy;
  assign cmd  = ipl_cmd_e'(command_i);

  assign new_pair = {VALUE_WIDTH'(first_value_i), VALUE_WIDTH'(second_value_i)};

  // Request decode and list bookkeeping.
  ipl_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .req_i       (req),
    .cmd_i       (cmd),
    .position_i  (position_i),
    .count_i     (count_q),
    .shift_o     (shift),
    .sel_o       (sel),
    .status_o    (status),
    .take_pair_o (take_pair),
    .count_o     (count_next)
  );

  // Row of cells; cell i sees its lower and upper neighbors.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [PairW-1:0] lower;
    logic [PairW-1:0] upper;
    if (gi == 0) begin : g_first
      assign lower = new_pair;
    end else begin : g_mid_lo
      assign lower = cell_q[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_last
      assign upper = cell_q[gi];
    end else begin : g_mid_hi
      assign upper = cell_q[gi+1];
    end
    ipl_cell #(
      .INDEX  (gi),
      .IDX_W  (IdxW),
      .PAIR_W (PairW)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .sel_i   (sel),
      .new_i   (new_pair),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_q[gi])
    );
  end

  // Pair returned by remove and read, taken before the row shifts.
  assign rd_pair = take_pair ? cell_q[sel] : '0;

  assign count_d = req ? count_next : count_q;

  // Control state: entry count and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= req;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (req) begin
      status_q <= status;
      first_q  <= rd_pair[PairW-1:VALUE_WIDTH];
      second_q <= rd_pair[VALUE_WIDTH-1:0];
    end
  end

  logic [CntW+CNT_O_W-1:0] count_wide;
  assign count_wide = (CntW + CNT_O_W)'(count_q);

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign pair_first_o   = FIELD_W'(first_q);
  assign pair_second_o  = FIELD_W'(second_q);
  assign entry_count_o  = count_wide[CNT_O_W-1:0];

  `IPL_ASSERT_NEXT(a_result_follows_req, clk_i, rst_ni, req, result_valid_o, "missing result")
  `IPL_ASSERT_NEXT(a_no_stray_result, clk_i, rst_ni, !req, !result_valid_o, "stray result")
  `IPL_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CAPACITY, "count overflow")
  `IPL_ASSERT_IMPL(a_error_pair_zero, clk_i, rst_ni, result_valid_o && status_q != ST_OK,
                   pair_first_o == '0 && pair_second_o == '0, "error result carries data")
  `IPL_ASSERT_NEXT(a_error_keeps_count, clk_i, rst_ni, req && status != ST_OK,
                   count_q == $past(count_q), "count changed on error")

endmodule

/* tb/indexed_pair_list_insert_remove_test.sv */
`timescale 1ns / 100ps

module indexed_pair_list_insert_remove_test;
  import ipl_pkg::*;

  localparam int LIST_DEPTH = 16;

  // One request as the generator plans it; hold_off marks a pause, not a request.
  typedef struct {
    ipl_cmd_e           op;
    logic [POS_W-1:0]   pos;
    logic [FIELD_W-1:0] first;
    logic [FIELD_W-1:0] second;
    bit                 hold_off;
  } list_req_t;

  // One result as the block should report it.
  typedef struct {
    ipl_status_e        status;
    logic [FIELD_W-1:0] first;
    logic [FIELD_W-1:0] second;
    logic [CNT_O_W-1:0] count;
  } list_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] command_i = CMD_READ;
  logic [POS_W-1:0] position_i = '0;
  logic [FIELD_W-1:0] first_value_i = '0;
  logic [FIELD_W-1:0] second_value_i = '0;
  logic result_valid_o;
  logic [1:0] status_o;
  logic [FIELD_W-1:0] pair_first_o;
  logic [FIELD_W-1:0] pair_second_o;
  logic [CNT_O_W-1:0] entry_count_o;

  list_req_t    pending_reqs[$];
  list_req_t    held_req;
  list_result_t expected_results[$];

  // Shadow copy of the list contents.
  logic [FIELD_W-1:0] shadow_first[LIST_DEPTH];
  logic [FIELD_W-1:0] shadow_second[LIST_DEPTH];
  int unsigned        shadow_len = 0;

  // Length estimate used only to aim generated positions.
  int unsigned plan_len = 0;

  int accepted_total = 0;
  int checked_total = 0;
  int mismatches = 0;
  int ok_seen = 0;
  int full_seen = 0;
  int range_seen = 0;
  int at_capacity_seen = 0;
  int emptied_seen = 0;

  indexed_pair_list_insert_remove #(
    .CAPACITY(LIST_DEPTH),
    .VALUE_WIDTH(FIELD_W)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .command_i(command_i),
    .position_i(position_i),
    .first_value_i(first_value_i),
    .second_value_i(second_value_i),
    .result_valid_o(result_valid_o),
    .status_o(status_o),
    .pair_first_o(pair_first_o),
    .pair_second_o(pair_second_o),
    .entry_count_o(entry_count_o)
  );

  always #4 clk_i = ~clk_i;

  // Apply an accepted request to the shadow list and queue the result it should give.
  function automatic void apply_request(input list_req_t req);
    list_result_t res;
    int unsigned  idx;
    res = '{ST_OK, '0, '0, '0};
    idx = req.pos;
    if (req.op == CMD_APPEND || req.op == CMD_INSERT) begin
      if (req.op == CMD_APPEND) idx = shadow_len;
      if (shadow_len >= LIST_DEPTH) begin
        res.status = ST_FULL;
      end else if (idx > shadow_len) begin
        res.status = ST_RANGE;
      end else begin
        for (int i = shadow_len; i > idx; i--) begin
          shadow_first[i]  = shadow_first[i-1];
          shadow_second[i] = shadow_second[i-1];
        end
        shadow_first[idx]  = req.first;
        shadow_second[idx] = req.second;
        shadow_len++;
      end
    end else if (idx >= shadow_len) begin
      res.status = ST_RANGE;
    end else begin
      res.first  = shadow_first[idx];
      res.second = shadow_second[idx];
      if (req.op == CMD_REMOVE) begin
        for (int i = idx; i + 1 < shadow_len; i++) begin
          shadow_first[i]  = shadow_first[i+1];
          shadow_second[i] = shadow_second[i+1];
        end
        shadow_len--;
      end
    end
    res.count = shadow_len[CNT_O_W-1:0];
    expected_results = {expected_results, res};
  endfunction

  // Queue a request and track roughly how long the list will be.
  task automatic queue_request(input ipl_cmd_e op, input int unsigned pos,
                               input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
    list_req_t req;
    req = '{op, pos[POS_W-1:0], a, b, 1'b0};
    pending_reqs = {pending_reqs, req};
    case (op)
      CMD_APPEND: if (plan_len < LIST_DEPTH) plan_len++;
      CMD_INSERT: if (plan_len < LIST_DEPTH && pos <= plan_len) plan_len++;
      CMD_REMOVE: if (pos < plan_len) plan_len--;
      default: ;
    endcase
  endtask

  // Queue a pause: the sender waits until every outstanding result has come back.
  task automatic queue_pause();
    list_req_t req;
    req = '{CMD_READ, '0, '0, '0, 1'b1};
    pending_reqs = {pending_reqs, req};
  endtask

  function automatic logic [FIELD_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return $urandom;
  endfunction

  // Driver: record the request taken at this edge, then present the next one or idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        apply_request(held_req);
        accepted_total++;
      end
      if (!start || !busy) begin
        if (pending_reqs.size() == 0) begin
          start <= 1'b0;
        end else if (pending_reqs[0].hold_off) begin
          start <= 1'b0;
          if (expected_results.size() == 0) void'(pending_reqs.pop_front());
        end else if ((accepted_total < 300 || accepted_total >= 450) &&
                     $urandom_range(99) < 15) begin
          start <= 1'b0;
        end else begin
          held_req = pending_reqs.pop_front();
          start          <= 1'b1;
          command_i      <= held_req.op;
          position_i     <= held_req.pos;
          first_value_i  <= held_req.first;
          second_value_i <= held_req.second;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin : check_result
      list_result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d, count %0d", status_o, entry_count_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        checked_total++;
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (pair_first_o !== want.first) begin
          $error("pair_first: expected %h, got %h", want.first, pair_first_o);
          mismatches++;
        end
        if (pair_second_o !== want.second) begin
          $error("pair_second: expected %h, got %h", want.second, pair_second_o);
          mismatches++;
        end
        if (entry_count_o !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count_o);
          mismatches++;
        end
        case (want.status)
          ST_OK:    ok_seen++;
          ST_FULL:  full_seen++;
          default:  range_seen++;
        endcase
        if (want.count == LIST_DEPTH) at_capacity_seen++;
        if (want.count == 0) emptied_seen++;
      end
    end
  end

  // Stimulus, then wait for the last results and report.
  initial begin
    ipl_cmd_e    op;
    int unsigned pos;
    int unsigned roll;
    bit          grow;
    int          drain_wait;

    // Directed part: empty list errors, edges of insert, middle moves, full list.
    queue_request(CMD_READ, 0, '1, '1);
    queue_request(CMD_REMOVE, 0, '0, '0);
    queue_request(CMD_INSERT, 1, 32'h1234_5678, 32'h9abc_def0);
    queue_request(CMD_INSERT, 0, '1, '0);
    queue_request(CMD_APPEND, 15, '0, '1);
    queue_request(CMD_INSERT, 2, 32'hdead_beef, 32'h0bad_f00d);
    queue_request(CMD_INSERT, 1, 32'h5555_aaaa, 32'haaaa_5555);
    queue_request(CMD_INSERT, 15, 32'h0000_0001, 32'h8000_0000);
    queue_request(CMD_READ, 3, '0, '0);
    queue_request(CMD_READ, 4, '0, '0);
    queue_request(CMD_REMOVE, 4, '0, '0);
    queue_request(CMD_REMOVE, 1, '0, '0);
    queue_request(CMD_REMOVE, 0, '0, '0);
    for (int i = 0; i < 14; i++) queue_request(CMD_APPEND, i, $urandom, $urandom);
    queue_request(CMD_APPEND, 0, '1, '1);
    queue_request(CMD_INSERT, 15, '1, '1);
    queue_request(CMD_READ, 15, '0, '0);
    queue_request(CMD_REMOVE, 15, '0, '0);
    queue_pause();

    // Random part: phases that lean toward filling and toward emptying the list.
    for (int n = 0; n < 720; n++) begin
      grow = ((n / 60) % 2) == 0;
      roll = $urandom_range(99);
      if (roll < (grow ? 60 : 20)) op = $urandom_range(1) ? CMD_APPEND : CMD_INSERT;
      else if (roll < (grow ? 80 : 70)) op = CMD_REMOVE;
      else op = CMD_READ;
      if (op == CMD_APPEND || $urandom_range(99) < 10) pos = $urandom_range(15);
      else if (op == CMD_INSERT) pos = $urandom_range(plan_len);
      else if (plan_len > 0) pos = $urandom_range(plan_len - 1);
      else pos = $urandom_range(15);
      queue_request(op, pos, pick_value(), pick_value());
      if (n == 360) queue_pause();
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (pending_reqs.size() != 0 || start);
    drain_wait = 0;
    while (expected_results.size() != 0 && drain_wait < 200) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (4) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      mismatches++;
    end

    $display("Checked %0d of %0d requests: %0d ok, %0d list full, %0d out of range.",
             checked_total, accepted_total, ok_seen, full_seen, range_seen);
    $display("The list was at capacity after %0d requests and empty after %0d.",
             at_capacity_seen, emptied_seen);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/ipl_pkg.sv
src/ipl_cell.sv
src/ipl_ctrl.sv
src/indexed_pair_list_insert_remove.sv
tb/indexed_pair_list_insert_remove_test.sv
